FILE: hw/rtl/rounded_gradient_bar_pixel_defines.svh
// Assertion macros shared by the rounded gradient bar pixel RTL.
`ifndef ROUNDED_GRADIENT_BAR_PIXEL_DEFINES_SVH
`define ROUNDED_GRADIENT_BAR_PIXEL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RGBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgbp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RGBP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgbp: next-cycle check failed");

`endif

FILE: hw/rtl/rgbp_pkg.sv
// Constants and types for the rounded gradient bar pixel generator.
package rgbp_pkg;

    // Config register map (word index)
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_BAR_WIDTH    = 3'd0;
    localparam logic [2:0] REG_BAR_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_TOP_COLOR    = 3'd2;
    localparam logic [2:0] REG_BOTTOM_COLOR = 3'd3;
    localparam logic [2:0] REG_BORDER_COLOR = 3'd4;
    localparam logic [2:0] REG_ROUNDED_ENDS = 3'd5;
    localparam logic [2:0] REG_STRIPED      = 3'd6;

    // Sprite size limits; larger register values saturate here
    localparam logic [6:0] MAX_WIDTH  = 7'd64;
    localparam logic [5:0] MAX_HEIGHT = 6'd32;

    // Reset values of the geometry registers
    localparam logic [6:0] RESET_WIDTH  = 7'd48;
    localparam logic [5:0] RESET_HEIGHT = 6'd18;

    // Four channels: red, green, blue, alpha (red in the top byte)
    localparam int CH_N = 4;
    typedef logic [7:0] chan_t;

    // Reciprocals ceil(2^18 / t) for t = 1..31; exact floor division for
    // dividends below 2^13. Entry zero is unused (single-row sprite).
    localparam int RECIP_SHIFT = 18;
    localparam logic [18:0] RECIP_TABLE [32] = '{
        19'd0,      19'd262144, 19'd131072, 19'd87382,  19'd65536,  19'd52429,
        19'd43691,  19'd37450,  19'd32768,  19'd29128,  19'd26215,  19'd23832,
        19'd21846,  19'd20165,  19'd18725,  19'd17477,  19'd16384,  19'd15421,
        19'd14564,  19'd13798,  19'd13108,  19'd12484,  19'd11916,  19'd11398,
        19'd10923,  19'd10486,  19'd10083,  19'd9710,   19'd9363,   19'd9040,
        19'd8739,   19'd8457
    };

    // Divide by five for values below 256: (n * 205) >> 10
    localparam logic [7:0] LIGHT_MUL   = 8'd205;
    localparam int         LIGHT_SHIFT = 10;

endpackage

FILE: hw/rtl/rounded_gradient_bar_pixel.sv
// Rounded gradient bar pixel generator: APB config, four-stage pixel pipeline.
//
// Usage: program the sprite geometry and colors over the APB port while the
// pixel stream is idle (bar_width, bar_height, top/bottom/border colors,
// rounded_ends, striped). Then send (s_col, s_row) coordinates on the
// s_ valid/ready channel; each transaction yields one RGBA pixel on the
// m_ channel (m_red, m_green, m_blue, m_alpha), in order.
// Throughput: one pixel per clock unless the receiver stalls, through the four
// register stages (range check and cap offsets, cap distance and gradient
// product, reciprocal multiply, final blend).
// Each stage holds a valid bit and advances when the stage ahead is free,
// so bubbles close up and s_ready stays high while any stage is empty,
// even with a result waiting on a stalled receiver. A stalled receiver
// backs the pipeline up; nothing is dropped or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the
// register defaults: width 48, height 18, colors zero, both options off.
// There is no clearing pass; the block accepts pixels right after reset.
`include "rounded_gradient_bar_pixel_defines.svh"

module rounded_gradient_bar_pixel (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rgbp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Pixel coordinate channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [5:0]                   s_col,
    input  logic [4:0]                   s_row,
    // Pixel color channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_red,
    output logic [7:0]                   m_green,
    output logic [7:0]                   m_blue,
    output logic [7:0]                   m_alpha
);
    import rgbp_pkg::*;

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [6:0]  bar_width_reg;
    logic [5:0]  bar_height_reg;
    logic [31:0] top_color_reg;
    logic [31:0] bottom_color_reg;
    logic [31:0] border_color_reg;
    logic        rounded_ends_reg;
    logic        striped_reg;
    logic        cfg_write;
    logic [2:0]  reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_width_reg    <= RESET_WIDTH;
            bar_height_reg   <= RESET_HEIGHT;
            top_color_reg    <= '0;
            bottom_color_reg <= '0;
            border_color_reg <= '0;
            rounded_ends_reg <= 1'b0;
            striped_reg      <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_BAR_WIDTH:    bar_width_reg    <= pwdata[6:0];
                REG_BAR_HEIGHT:   bar_height_reg   <= pwdata[5:0];
                REG_TOP_COLOR:    top_color_reg    <= pwdata;
                REG_BOTTOM_COLOR: bottom_color_reg <= pwdata;
                REG_BORDER_COLOR: border_color_reg <= pwdata;
                REG_ROUNDED_ENDS: rounded_ends_reg <= pwdata[0];
                REG_STRIPED:      striped_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_sel)
            REG_BAR_WIDTH:    prdata = {25'd0, bar_width_reg};
            REG_BAR_HEIGHT:   prdata = {26'd0, bar_height_reg};
            REG_TOP_COLOR:    prdata = top_color_reg;
            REG_BOTTOM_COLOR: prdata = bottom_color_reg;
            REG_BORDER_COLOR: prdata = border_color_reg;
            REG_ROUNDED_ENDS: prdata = {31'd0, rounded_ends_reg};
            REG_STRIPED:      prdata = {31'd0, striped_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Derived geometry (kept static by the user while pixels flow; not enforced)
    // ---------------------------------------------------------------
    logic [6:0]        w_sat;
    logic [5:0]        h_sat;
    logic [4:0]        rad;
    logic [4:0]        total;
    logic              single_row;
    logic signed [7:0] w_minus_r;
    logic [9:0]        rad_sq;
    chan_t             top_ch [CH_N];
    chan_t             bot_ch [CH_N];
    chan_t             brd_ch [CH_N];

    always_comb begin
        w_sat      = (bar_width_reg > MAX_WIDTH) ? MAX_WIDTH : bar_width_reg;
        h_sat      = (bar_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : bar_height_reg;
        rad        = h_sat[5:1];
        total      = 5'(h_sat - 6'd1);
        single_row = (h_sat == 6'd1);
        w_minus_r  = $signed({1'b0, w_sat}) - $signed({3'b000, rad});
        rad_sq     = {5'd0, rad} * {5'd0, rad};
        for (int c = 0; c < CH_N; c++) begin
            top_ch[c] = top_color_reg[(CH_N-1-c)*8 +: 8];
            bot_ch[c] = bottom_color_reg[(CH_N-1-c)*8 +: 8];
            brd_ch[c] = border_color_reg[(CH_N-1-c)*8 +: 8];
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or the
    // stage ahead takes its content
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: range check, cap offsets, stripe and border flags
    // ---------------------------------------------------------------
    logic              in_range_next, cap_next, stripe_next, border_next;
    logic [3:0]        dx_next;
    logic signed [4:0] dy_next;
    logic              left_cap, right_cap;
    logic [6:0]        dy_full;
    logic [5:0]        dx_left;
    logic [7:0]        dx_right;
    logic [6:0]        col_plus_r;

    always_comb begin
        in_range_next = ({1'b0, s_col} < w_sat) && ({1'b0, s_row} < h_sat);
        // left cap wins when the caps overlap
        left_cap   = s_col < {1'b0, rad};
        right_cap  = $signed({2'b00, s_col}) >= w_minus_r;
        dy_full    = {2'b00, rad} - {2'b00, s_row} - 7'd1;
        dx_left    = {1'b0, rad} - s_col - 6'd1;
        dx_right   = {2'b00, s_col} + {3'b000, rad} - {1'b0, w_sat};
        dx_next    = left_cap ? dx_left[3:0] : dx_right[3:0];
        dy_next    = $signed(dy_full[4:0]);
        cap_next   = rounded_ends_reg && (left_cap || right_cap);
        col_plus_r = {1'b0, s_col} + {2'b00, rad};
        // stripes: even four-column groups right of column rad, left of the right cap
        stripe_next = striped_reg && !s_col[2] && (s_col > {1'b0, rad})
                      && (col_plus_r < w_sat);
        border_next = (s_row == 5'd0) || ({1'b0, s_row} == h_sat - 6'd1)
                      || (s_col == 6'd0) || ({1'b0, s_col} == w_sat - 7'd1);
    end

    logic              s1_in_range_reg, s1_cap_reg, s1_stripe_reg, s1_border_reg;
    logic [3:0]        s1_dx_reg;
    logic signed [4:0] s1_dy_reg;
    logic [4:0]        s1_row_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_in_range_reg <= in_range_next;
            s1_cap_reg      <= cap_next;
            s1_stripe_reg   <= stripe_next;
            s1_border_reg   <= border_next;
            s1_dx_reg       <= dx_next;
            s1_dy_reg       <= dy_next;
            s1_row_reg      <= s_row;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: cap distance test, gradient numerators |B-A| * row
    // ---------------------------------------------------------------
    logic [4:0]  dy_mag;
    logic [9:0]  cap_dist;
    logic        inside_next;
    logic [8:0]  diff [CH_N];
    logic [7:0]  diff_mag [CH_N];
    logic [12:0] prod_next [CH_N];
    logic        neg_next [CH_N];

    always_comb begin
        dy_mag   = s1_dy_reg[4] ? (5'd0 - s1_dy_reg) : s1_dy_reg;
        cap_dist = ({6'd0, s1_dx_reg} * {6'd0, s1_dx_reg})
                   + ({5'd0, dy_mag} * {5'd0, dy_mag});
        inside_next = s1_in_range_reg && !(s1_cap_reg && (cap_dist > rad_sq));
        for (int c = 0; c < CH_N; c++) begin
            diff[c]      = {1'b0, bot_ch[c]} - {1'b0, top_ch[c]};
            neg_next[c]  = diff[c][8];
            diff_mag[c]  = 8'(diff[c][8] ? (9'd0 - diff[c]) : diff[c]);
            prod_next[c] = {5'd0, diff_mag[c]} * {8'd0, s1_row_reg};
        end
    end

    logic        s2_inside_reg, s2_stripe_reg, s2_border_reg;
    logic [12:0] s2_prod_reg [CH_N];
    logic        s2_neg_reg [CH_N];

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_inside_reg <= inside_next;
            s2_stripe_reg <= s1_stripe_reg;
            s2_border_reg <= s1_border_reg;
            for (int c = 0; c < CH_N; c++) begin
                s2_prod_reg[c] <= prod_next[c];
                s2_neg_reg[c]  <= neg_next[c];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: divide by (h-1) through reciprocal multiply
    // ---------------------------------------------------------------
    logic [18:0] recip;
    logic [31:0] quot_wide [CH_N];
    chan_t       quot_next [CH_N];
    logic        quot_hi;

    always_comb begin
        recip   = RECIP_TABLE[total];
        quot_hi = 1'b0;
        for (int c = 0; c < CH_N; c++) begin
            quot_wide[c] = {19'd0, s2_prod_reg[c]} * {13'd0, recip};
            // single row: the gradient is the top color
            quot_next[c] = single_row ? 8'd0
                         : quot_wide[c][RECIP_SHIFT +: 8];
            quot_hi      = quot_hi || (quot_wide[c][31:RECIP_SHIFT+8] != '0);
        end
    end

    logic  s3_inside_reg, s3_stripe_reg, s3_border_reg;
    chan_t s3_quot_reg [CH_N];
    logic  s3_neg_reg [CH_N];

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_inside_reg <= s2_inside_reg;
            s3_stripe_reg <= s2_stripe_reg;
            s3_border_reg <= s2_border_reg;
            for (int c = 0; c < CH_N; c++) begin
                s3_quot_reg[c] <= quot_next[c];
                s3_neg_reg[c]  <= s2_neg_reg[c];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: gradient value, stripe lighten, border/outside select
    // ---------------------------------------------------------------
    chan_t       grad [CH_N];
    logic [15:0] light_prod [CH_N];
    chan_t       light [CH_N];
    chan_t       pix_next [CH_N];

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            grad[c] = s3_neg_reg[c] ? (top_ch[c] - s3_quot_reg[c])
                                    : (top_ch[c] + s3_quot_reg[c]);
            // c + (255 - c) / 5
            light_prod[c] = {8'd0, ~grad[c]} * {8'd0, LIGHT_MUL};
            light[c]      = grad[c] + 8'(light_prod[c] >> LIGHT_SHIFT);
            priority if (!s3_inside_reg) begin
                pix_next[c] = 8'd0;
            end else if (s3_border_reg) begin
                pix_next[c] = brd_ch[c];
            end else if (s3_stripe_reg) begin
                pix_next[c] = light[c];
            end else begin
                pix_next[c] = grad[c];
            end
        end
    end

    chan_t s4_pix_reg [CH_N];

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            for (int c = 0; c < CH_N; c++) begin
                s4_pix_reg[c] <= pix_next[c];
            end
        end
    end

    assign m_red   = s4_pix_reg[0];
    assign m_green = s4_pix_reg[1];
    assign m_blue  = s4_pix_reg[2];
    assign m_alpha = s4_pix_reg[3];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // input blocked only when every stage is occupied
    `RGBP_ASSERT_IMP(a_blocked_only_when_full, !s_ready, v1_reg && v2_reg && v3_reg && v4_reg)
    // an item handed to the output stage shows up as a valid result
    `RGBP_ASSERT_NXT(a_output_stage_loads, v3_reg && rdy4, m_valid)
    // interpolation quotient fits one channel for pixels inside the shape
    `RGBP_ASSERT_IMP(a_quotient_in_range, v2_reg && s2_inside_reg, !quot_hi)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the rounded gradient bar pixel generator.
module testbench;
    import rgbp_pkg::*;

    // Index with no register behind it; writes there must be dropped
    localparam logic [2:0] REG_SPARE = 3'd7;

    // Predicts pixel colors from a shadow copy of the registers and checks results
    class pixel_color_checker;
        logic [6:0]  width_r;
        logic [5:0]  height_r;
        logic [31:0] top_r;
        logic [31:0] bottom_r;
        logic [31:0] border_r;
        logic        rounded_r;
        logic        striped_r;
        logic [31:0] pending_colors [$];
        int          errors;
        int          checked;

        function new();
            width_r   = RESET_WIDTH;
            height_r  = RESET_HEIGHT;
            top_r     = '0;
            bottom_r  = '0;
            border_r  = '0;
            rounded_r = 1'b0;
            striped_r = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_BAR_WIDTH:    width_r   = data[6:0];
                REG_BAR_HEIGHT:   height_r  = data[5:0];
                REG_TOP_COLOR:    top_r     = data;
                REG_BOTTOM_COLOR: bottom_r  = data;
                REG_BORDER_COLOR: border_r  = data;
                REG_ROUNDED_ENDS: rounded_r = data[0];
                REG_STRIPED:      striped_r = data[0];
                default: ;
            endcase
        endfunction

        // Per-channel vertical blend, signed, truncated toward zero
        function logic [31:0] row_gradient(int y, int total);
            logic [31:0] res;
            int a, b, v;
            if (total <= 0) return top_r;
            res = '0;
            for (int sh = 24; sh >= 0; sh -= 8) begin
                a = int'(top_r[sh +: 8]);
                b = int'(bottom_r[sh +: 8]);
                v = a + ((b - a) * y) / total;
                res[sh +: 8] = v[7:0];
            end
            return res;
        endfunction

        // One fifth of the way toward white, every channel
        function logic [31:0] toward_white(logic [31:0] c);
            logic [31:0] res;
            int a, v;
            res = '0;
            for (int sh = 24; sh >= 0; sh -= 8) begin
                a = int'(c[sh +: 8]);
                v = a + (255 - a) / 5;
                res[sh +: 8] = v[7:0];
            end
            return res;
        endfunction

        function logic [31:0] pixel_color(logic [5:0] col, logic [4:0] row);
            int x, y, w, h, r, dx, dy;
            bit in_shape;
            logic [31:0] color;
            x = int'(col);
            y = int'(row);
            w = (width_r > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(width_r);
            h = (height_r > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(height_r);
            r = h / 2;
            color = '0;
            in_shape = (x < w) && (y < h);
            // end caps; left cap wins when they overlap
            if (in_shape && rounded_r) begin
                dy = r - y - 1;
                if (x < r) begin
                    dx = r - x - 1;
                    in_shape = (dx * dx + dy * dy) <= r * r;
                end else if (x >= w - r) begin
                    dx = x - (w - r);
                    in_shape = (dx * dx + dy * dy) <= r * r;
                end
            end
            if (in_shape) begin
                color = row_gradient(y, h - 1);
                if (striped_r && ((x / 4) % 2 == 0) && x > r && x < w - r)
                    color = toward_white(color);
                if (y == 0 || y == h - 1 || x == 0 || x == w - 1)
                    color = border_r;
            end
            return color;
        endfunction

        function void note_pixel(logic [5:0] col, logic [4:0] row);
            pending_colors.push_back(pixel_color(col, row));
        endfunction

        function int pending();
            return pending_colors.size();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                         logic [7:0] alpha);
            logic [31:0] want;
            if (pending_colors.size() == 0) begin
                report($sformatf("pixel %0d arrived with nothing pending", checked));
                return;
            end
            want = pending_colors.pop_front();
            if (red !== want[31:24])
                report($sformatf("pixel %0d red %h, want %h", checked, red, want[31:24]));
            if (green !== want[23:16])
                report($sformatf("pixel %0d green %h, want %h", checked, green, want[23:16]));
            if (blue !== want[15:8])
                report($sformatf("pixel %0d blue %h, want %h", checked, blue, want[15:8]));
            if (alpha !== want[7:0])
                report($sformatf("pixel %0d alpha %h, want %h", checked, alpha, want[7:0]));
            checked++;
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [5:0]           s_col;
    logic [4:0]           s_row;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_red;
    logic [7:0]           m_green;
    logic [7:0]           m_blue;
    logic [7:0]           m_alpha;

    pixel_color_checker sb;
    bit                 idle_on;
    int                 n_settings;

    rounded_gradient_bar_pixel dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_col   (s_col),
        .s_row   (s_row),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_red   (m_red),
        .m_green (m_green),
        .m_blue  (m_blue),
        .m_alpha (m_alpha)
    );

    // 10-unit clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stall bursts while idling is on
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_red, m_green, m_blue, m_alpha);
    end

    // APB register write: setup cycle, then access cycle
    task apb_write(logic [2:0] idx, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One coordinate transaction, with an optional idle burst ahead of it
    task send_pixel(logic [5:0] col, logic [4:0] row);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_col   <= col;
        s_row   <= row;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(col, row);
    endtask

    // Stop the stream and let the pipeline empty
    task wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function logic [31:0] pick_color();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Program a full register set; low kinds force the size extremes
    task load_settings(int kind);
        logic [6:0] w;
        logic [5:0] h;
        logic       rnd, stp;
        w   = 7'($urandom_range(1, 64));
        h   = 6'($urandom_range(1, 32));
        rnd = 1'($urandom_range(0, 1));
        stp = 1'($urandom_range(0, 1));
        case (kind)
            0: begin w = 7'd64; h = 6'd32; rnd = 1'b1; stp = 1'b1; end
            1: begin w = 7'd1; h = 6'd1; end
            2: begin w = 7'd127; h = 6'd63; rnd = 1'b1; end
            3: w = 7'd0;
            4: h = 6'd0;
            5: begin w = 7'd2; h = 6'd2; rnd = 1'b1; stp = 1'b1; end
            6: begin h = 6'd1; rnd = 1'b1; end
            default: begin
                if ($urandom_range(0, 7) == 0) w = 7'($urandom_range(65, 127));
                if ($urandom_range(0, 7) == 0) h = 6'($urandom_range(33, 63));
            end
        endcase
        // junk in the unused upper bits must be dropped
        apb_write(REG_BAR_WIDTH, ($urandom() & 32'hFFFF_FF80) | 32'(w));
        apb_write(REG_BAR_HEIGHT, ($urandom() & 32'hFFFF_FFC0) | 32'(h));
        apb_write(REG_TOP_COLOR, pick_color());
        apb_write(REG_BOTTOM_COLOR, pick_color());
        apb_write(REG_BORDER_COLOR, pick_color());
        apb_write(REG_ROUNDED_ENDS, ($urandom() & 32'hFFFF_FFFE) | 32'(rnd));
        apb_write(REG_STRIPED, ($urandom() & 32'hFFFF_FFFE) | 32'(stp));
        apb_write(REG_SPARE, $urandom());
        n_settings++;
    endtask

    // Random pixels, mostly within the sprite, some on its edges, some anywhere
    task run_pixels(int count);
        int wlim, hlim;
        logic [5:0] col;
        logic [4:0] row;
        wlim = (sb.width_r > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(sb.width_r);
        hlim = (sb.height_r > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(sb.height_r);
        for (int i = 0; i < count; i++) begin
            col = 6'($urandom());
            row = 5'($urandom());
            if (wlim > 0 && hlim > 0) begin
                case ($urandom_range(0, 7))
                    0, 1: ;
                    2: begin
                        col = 6'($urandom_range(0, wlim - 1));
                        row = $urandom_range(0, 1) ? 5'd0 : 5'(hlim - 1);
                    end
                    3: begin
                        col = $urandom_range(0, 1) ? 6'd0 : 6'(wlim - 1);
                        row = 5'($urandom_range(0, hlim - 1));
                    end
                    default: begin
                        col = 6'($urandom_range(0, wlim - 1));
                        row = 5'($urandom_range(0, hlim - 1));
                    end
                endcase
            end
            send_pixel(col, row);
        end
        wait_drained();
    endtask

    // Stimulus
    initial begin
        sb         = new();
        idle_on    = 1'b1;
        n_settings = 1;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_col      = '0;
        s_row      = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset geometry: corners and just past the edges
        send_pixel(6'd0, 5'd0);
        send_pixel(6'd47, 5'd17);
        send_pixel(6'd48, 5'd5);
        send_pixel(6'd10, 5'd18);
        send_pixel(6'd63, 5'd31);
        wait_drained();

        // full-size sprite with caps and stripes, black to white
        apb_write(REG_BAR_WIDTH, 32'd64);
        apb_write(REG_BAR_HEIGHT, 32'd32);
        apb_write(REG_TOP_COLOR, 32'h0000_0000);
        apb_write(REG_BOTTOM_COLOR, 32'hFFFF_FFFF);
        apb_write(REG_BORDER_COLOR, 32'h5AA5_C33C);
        apb_write(REG_ROUNDED_ENDS, 32'd1);
        apb_write(REG_STRIPED, 32'd1);
        n_settings++;
        send_pixel(6'd0, 5'd0);     // cut by left cap
        send_pixel(6'd63, 5'd31);   // cut by right cap
        send_pixel(6'd0, 5'd15);    // cap edge, border
        send_pixel(6'd63, 5'd15);
        send_pixel(6'd16, 5'd0);    // top border
        send_pixel(6'd20, 5'd31);   // bottom border
        send_pixel(6'd8, 5'd16);    // inside left cap
        send_pixel(6'd48, 5'd15);   // right cap center
        send_pixel(6'd16, 5'd16);   // stripe column, at the radius
        send_pixel(6'd17, 5'd16);   // stripe
        send_pixel(6'd20, 5'd10);   // odd column group
        send_pixel(6'd40, 5'd20);   // stripe near right cap
        send_pixel(6'd47, 5'd30);
        send_pixel(6'd31, 5'd1);
        wait_drained();

        // single-row sprite: its one row is all border, the next row is outside
        apb_write(REG_BAR_HEIGHT, 32'd1);
        apb_write(REG_ROUNDED_ENDS, 32'd0);
        n_settings++;
        send_pixel(6'd5, 5'd0);
        send_pixel(6'd0, 5'd0);
        send_pixel(6'd5, 5'd1);
        wait_drained();

        // random phases; the last two run without idling
        for (int p = 0; p < 12; p++) begin
            if (p >= 10) idle_on = 1'b0;
            load_settings(p);
            run_pixels(125);
        end

        $display("Summary: %0d pixels checked over %0d register settings", sb.checked,
                 n_settings);
        $display("Summary: caps, stripes, borders, single-row, empty and oversized sprites");
        if (sb.errors == 0) begin
            $display("** rounded_gradient_bar_pixel: PASSED **");
        end else begin
            $display("** rounded_gradient_bar_pixel: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("** rounded_gradient_bar_pixel: FAILED **");
        $finish;
    end

endmodule
